// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the project.
// Depends on nothing; users provide clk and rst_n in their scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SGI_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define SGI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/sgi_pkg.sv -----
// Shared constants and types of the segment intersection unit.
// Depends on nothing.
package sgi_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Number of register stages of the front end.
    localparam int FRONT_STAGES = 4;

    typedef struct packed {
        logic hit;
        logic par;
    } sgi_flags_t;

endpackage

// ----- rtl/core/segment_intersection_unit.sv -----
// Segment intersection unit, top level: pipeline control and stream ports.
// Depends on sgi_pkg, sgi_front, sgi_div and sgi_out.
//
// The unit takes two line segments P and Q per request and returns one result per
// request: the crossing point of the two infinite lines in signed fixed point with
// FRAC_BITS fraction bits (width COORD_BITS+FRAC_BITS+2, clamped to that range with
// point_saturated set), a hit flag when both line parameters lie in [0,1] inclusive,
// and a parallel flag when the denominator is zero, in which case the point and the
// other flags are zero. Rounding of the point is to nearest, ties away from zero.
// The unit is fully pipelined and takes one request every cycle unless the
// pipeline holds. Its stages are four front stages for the differences, cross
// products and magnitudes, one setup stage and one stage per quotient bit in each
// of the two dividers, and one output stage. The whole pipeline advances together;
// it holds only while a result waits at the output and the sink is not ready. The
// results come back in request order.
module segment_intersection_unit
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [8*COORD_BITS-1:0]                               s_tdata,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // cross_x, cross_y, zero padding to whole bytes
    output logic [((2*(COORD_BITS+FRAC_BITS+2)+7)/8)*8-1:0]       m_tdata,
    // segments_hit, lines_parallel, point_saturated
    output logic [2:0]                                            m_tuser
);

    localparam int OB     = COORD_BITS + FRAC_BITS + 2;
    localparam int OUT_W  = ((2 * OB + 7) / 8) * 8;
    localparam int STAGES = FRONT_STAGES + OB + 2;
    localparam int TX_W   = COORD_BITS + 3;
    localparam int TY_W   = COORD_BITS + 1;

    logic [STAGES-1:0] vld_reg;
    logic              adv;

    logic signed [COORD_BITS-1:0] start_x, start_y;
    logic neg_x, neg_y;
    sgi_flags_t f_flags, d_flags;
    logic [3*COORD_BITS+3:0] prod_x, prod_y;
    logic [2*COORD_BITS+2:0] den_mag;
    logic [TX_W-1:0] tag_x;
    logic [TY_W-1:0] tag_y;
    logic [OB-1:0] quot_x, quot_y, cross_x, cross_y;
    logic ovf_x, ovf_y;
    logic segments_hit, lines_parallel, point_saturated;

    // All stages move together whenever the output register is free or being taken.
    assign adv      = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
        end
    end

    sgi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .en      (adv),
        .p1x     (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .p1y     (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .p2x     (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .p2y     (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .q1x     (s_tdata[4*COORD_BITS +: COORD_BITS]),
        .q1y     (s_tdata[5*COORD_BITS +: COORD_BITS]),
        .q2x     (s_tdata[6*COORD_BITS +: COORD_BITS]),
        .q2y     (s_tdata[7*COORD_BITS +: COORD_BITS]),
        .start_x (start_x),
        .start_y (start_y),
        .neg_x   (neg_x),
        .neg_y   (neg_y),
        .flags   (f_flags),
        .prod_x  (prod_x),
        .prod_y  (prod_y),
        .den_mag (den_mag)
    );

    // The x divider carries the flags and start point x; the y divider start point y.
    sgi_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TAG_W      (TX_W)
    ) u_div_x (
        .clk     (clk),
        .en      (adv),
        .prod    (prod_x),
        .den_mag (den_mag),
        .tag_in  ({neg_x, f_flags, start_x}),
        .quot    (quot_x),
        .ovf     (ovf_x),
        .tag_out (tag_x)
    );

    sgi_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TAG_W      (TY_W)
    ) u_div_y (
        .clk     (clk),
        .en      (adv),
        .prod    (prod_y),
        .den_mag (den_mag),
        .tag_in  ({neg_y, start_y}),
        .quot    (quot_y),
        .ovf     (ovf_y),
        .tag_out (tag_y)
    );

    assign d_flags = tag_x[COORD_BITS +: 2];

    sgi_out #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_out (
        .clk             (clk),
        .en              (adv),
        .quot_x          (quot_x),
        .ovf_x           (ovf_x),
        .neg_x           (tag_x[TX_W-1]),
        .start_x         (tag_x[COORD_BITS-1:0]),
        .quot_y          (quot_y),
        .ovf_y           (ovf_y),
        .neg_y           (tag_y[TY_W-1]),
        .start_y         (tag_y[COORD_BITS-1:0]),
        .flags           (d_flags),
        .segments_hit    (segments_hit),
        .lines_parallel  (lines_parallel),
        .point_saturated (point_saturated),
        .cross_x         (cross_x),
        .cross_y         (cross_y)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = OUT_W'({cross_y, cross_x});
    assign m_tuser  = {point_saturated, lines_parallel, segments_hit};

endmodule

// ----- rtl/core/sgi_front.sv -----
// Front end: differences, cross products, magnitudes and segment flags.
// Depends on sgi_pkg.
module sgi_front
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [COORD_BITS-1:0]      p1x,
    input  logic signed [COORD_BITS-1:0]      p1y,
    input  logic signed [COORD_BITS-1:0]      p2x,
    input  logic signed [COORD_BITS-1:0]      p2y,
    input  logic signed [COORD_BITS-1:0]      q1x,
    input  logic signed [COORD_BITS-1:0]      q1y,
    input  logic signed [COORD_BITS-1:0]      q2x,
    input  logic signed [COORD_BITS-1:0]      q2y,
    output logic signed [COORD_BITS-1:0]      start_x,
    output logic signed [COORD_BITS-1:0]      start_y,
    output logic                              neg_x,
    output logic                              neg_y,
    output sgi_flags_t                        flags,
    output logic [3*COORD_BITS+3:0]           prod_x,
    output logic [3*COORD_BITS+3:0]           prod_y,
    output logic [2*COORD_BITS+2:0]           den_mag
);

    localparam int DW  = COORD_BITS + 1;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int PW  = 2 * COORD_BITS + 3;
    localparam int PPW = 3 * COORD_BITS + 4;

    // Stage 1
    logic signed [COORD_BITS-1:0] s1_px_reg, s1_py_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    // Stage 2
    logic signed [COORD_BITS-1:0] s2_px_reg, s2_py_reg;
    logic signed [DW-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [MW-1:0] aybx_reg, axby_reg, bycx_reg, bxcy_reg, axcy_reg, aycx_reg;
    // Stage 3
    logic signed [COORD_BITS-1:0] s3_px_reg, s3_py_reg;
    logic signed [DW-1:0] s3_ax_reg, s3_ay_reg;
    logic signed [PW-1:0] den_reg, na_reg, nb_reg;
    // Stage 4
    logic signed [COORD_BITS-1:0] s4_px_reg, s4_py_reg;
    logic neg_x_reg, neg_y_reg;
    sgi_flags_t flags_reg;
    logic [PPW-1:0] prod_x_reg, prod_y_reg;
    logic [PW-1:0] den_mag_reg;

    logic [DW-1:0] ax_mag, ay_mag;
    logic [PW-1:0] na_mag, den_mag_next;
    logic den_pos, in_a, in_b;

    always_comb
    begin
        ax_mag = s3_ax_reg[DW-1] ? DW'(-s3_ax_reg) : DW'(s3_ax_reg);
        ay_mag = s3_ay_reg[DW-1] ? DW'(-s3_ay_reg) : DW'(s3_ay_reg);
        na_mag = na_reg[PW-1] ? PW'(-na_reg) : PW'(na_reg);
        den_mag_next = den_reg[PW-1] ? PW'(-den_reg) : PW'(den_reg);
        den_pos = !den_reg[PW-1] && (den_reg != '0);
        in_a = den_pos ? (!na_reg[PW-1] && (na_reg <= den_reg))
                       : ((na_reg <= PW'(0)) && (na_reg >= den_reg));
        in_b = den_pos ? (!nb_reg[PW-1] && (nb_reg <= den_reg))
                       : ((nb_reg <= PW'(0)) && (nb_reg >= den_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_px_reg <= p1x;
            s1_py_reg <= p1y;
            ax_reg <= $signed({p2x[COORD_BITS-1], p2x}) - $signed({p1x[COORD_BITS-1], p1x});
            ay_reg <= $signed({p2y[COORD_BITS-1], p2y}) - $signed({p1y[COORD_BITS-1], p1y});
            bx_reg <= $signed({q1x[COORD_BITS-1], q1x}) - $signed({q2x[COORD_BITS-1], q2x});
            by_reg <= $signed({q1y[COORD_BITS-1], q1y}) - $signed({q2y[COORD_BITS-1], q2y});
            cx_reg <= $signed({p1x[COORD_BITS-1], p1x}) - $signed({q1x[COORD_BITS-1], q1x});
            cy_reg <= $signed({p1y[COORD_BITS-1], p1y}) - $signed({q1y[COORD_BITS-1], q1y});

            s2_px_reg <= s1_px_reg;
            s2_py_reg <= s1_py_reg;
            s2_ax_reg <= ax_reg;
            s2_ay_reg <= ay_reg;
            aybx_reg <= MW'(ay_reg) * MW'(bx_reg);
            axby_reg <= MW'(ax_reg) * MW'(by_reg);
            bycx_reg <= MW'(by_reg) * MW'(cx_reg);
            bxcy_reg <= MW'(bx_reg) * MW'(cy_reg);
            axcy_reg <= MW'(ax_reg) * MW'(cy_reg);
            aycx_reg <= MW'(ay_reg) * MW'(cx_reg);

            s3_px_reg <= s2_px_reg;
            s3_py_reg <= s2_py_reg;
            s3_ax_reg <= s2_ax_reg;
            s3_ay_reg <= s2_ay_reg;
            den_reg <= PW'(aybx_reg) - PW'(axby_reg);
            na_reg  <= PW'(bycx_reg) - PW'(bxcy_reg);
            nb_reg  <= PW'(axcy_reg) - PW'(aycx_reg);

            s4_px_reg <= s3_px_reg;
            s4_py_reg <= s3_py_reg;
            neg_x_reg <= s3_ax_reg[DW-1] ^ na_reg[PW-1] ^ den_reg[PW-1];
            neg_y_reg <= s3_ay_reg[DW-1] ^ na_reg[PW-1] ^ den_reg[PW-1];
            flags_reg.hit <= in_a && in_b;
            flags_reg.par <= (den_reg == '0);
            prod_x_reg <= PPW'(ax_mag) * PPW'(na_mag);
            prod_y_reg <= PPW'(ay_mag) * PPW'(na_mag);
            den_mag_reg <= den_mag_next;
        end
    end

    assign start_x = s4_px_reg;
    assign start_y = s4_py_reg;
    assign neg_x   = neg_x_reg;
    assign neg_y   = neg_y_reg;
    assign flags   = flags_reg;
    assign prod_x  = prod_x_reg;
    assign prod_y  = prod_y_reg;
    assign den_mag = den_mag_reg;

endmodule

// ----- rtl/core/sgi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounding to nearest.
// Depends on sgi_pkg.
module sgi_div
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int TAG_W      = 1
)
(
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [3*COORD_BITS+3:0]                 prod,
    input  logic [2*COORD_BITS+2:0]                 den_mag,
    input  logic [TAG_W-1:0]                        tag_in,
    output logic [COORD_BITS+FRAC_BITS+1:0]         quot,
    output logic                                    ovf,
    output logic [TAG_W-1:0]                        tag_out
);

    localparam int PPW = 3 * COORD_BITS + 4;
    localparam int K   = COORD_BITS + FRAC_BITS + 2;
    localparam int DWD = 2 * COORD_BITS + 4;
    localparam int NW  = PPW + FRAC_BITS + 2;

    logic [DWD-1:0]   rem_reg  [0:K];
    logic [DWD-1:0]   div_reg  [0:K];
    logic [K-1:0]     low_reg  [0:K];
    logic [K-1:0]     q_reg    [0:K];
    logic             ovf_reg  [0:K];
    logic [TAG_W-1:0] tag_reg  [0:K];

    logic [NW-1:0]  num;
    logic [DWD-1:0] div0;

    // Numerator is 2*prod*2^F + den, divisor 2*den: the floor gives the rounded result.
    always_comb
    begin
        num  = (NW'(prod) << (FRAC_BITS + 1)) + NW'(den_mag);
        div0 = {den_mag, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1:K];
            div_reg[0] <= div0;
            low_reg[0] <= num[K-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num[NW-1:K] >= div0);
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar j = 1; j <= K; j++)
    begin : g_step
        logic [DWD:0] trial;
        logic         ge;

        always_comb
        begin
            trial = {rem_reg[j-1], low_reg[j-1][K-1]};
            ge    = (trial >= {1'b0, div_reg[j-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? DWD'(trial - {1'b0, div_reg[j-1]}) : DWD'(trial);
                div_reg[j] <= div_reg[j-1];
                low_reg[j] <= low_reg[j-1] << 1;
                q_reg[j]   <= {q_reg[j-1][K-2:0], ge};
                ovf_reg[j] <= ovf_reg[j-1];
                tag_reg[j] <= tag_reg[j-1];
            end
        end
    end

    assign quot    = q_reg[K];
    assign ovf     = ovf_reg[K];
    assign tag_out = tag_reg[K];

endmodule

// ----- rtl/core/sgi_out.sv -----
// Output stage: applies sign, adds the start point and saturates.
// Depends on sgi_pkg.
module sgi_out
    import sgi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [COORD_BITS+FRAC_BITS+1:0]         quot_x,
    input  logic                                    ovf_x,
    input  logic                                    neg_x,
    input  logic signed [COORD_BITS-1:0]            start_x,
    input  logic [COORD_BITS+FRAC_BITS+1:0]         quot_y,
    input  logic                                    ovf_y,
    input  logic                                    neg_y,
    input  logic signed [COORD_BITS-1:0]            start_y,
    input  sgi_flags_t                              flags,
    output logic                                    segments_hit,
    output logic                                    lines_parallel,
    output logic                                    point_saturated,
    output logic [COORD_BITS+FRAC_BITS+1:0]         cross_x,
    output logic [COORD_BITS+FRAC_BITS+1:0]         cross_y
);

    localparam int OB = COORD_BITS + FRAC_BITS + 2;
    localparam int K  = OB;
    localparam logic signed [K+1:0] HI = {3'b000, {(OB-1){1'b1}}};
    localparam logic signed [K+1:0] LO = {3'b111, {(OB-1){1'b0}}};

    logic hit_reg, par_reg, sat_reg;
    logic [OB-1:0] x_reg, y_reg;
    logic [OB:0] fx, fy;

    // Returns the saturation flag above the clamped coordinate.
    function automatic logic [OB:0] place(input logic signed [COORD_BITS-1:0] p,
                                          input logic [K-1:0] q,
                                          input logic ovfl,
                                          input logic neg);
        logic signed [K+1:0] base;
        logic signed [K+1:0] sum;
        logic [OB:0] res;
        base = {{(K+2-COORD_BITS-FRAC_BITS){p[COORD_BITS-1]}}, p, {FRAC_BITS{1'b0}}};
        sum  = neg ? base - $signed({2'b00, q}) : base + $signed({2'b00, q});
        if (ovfl)
            res = {1'b1, neg ? LO[OB-1:0] : HI[OB-1:0]};
        else if (sum > HI)
            res = {1'b1, HI[OB-1:0]};
        else if (sum < LO)
            res = {1'b1, LO[OB-1:0]};
        else
            res = {1'b0, sum[OB-1:0]};
        return res;
    endfunction

    always_comb
    begin
        fx = place(start_x, quot_x, ovf_x, neg_x);
        fy = place(start_y, quot_y, ovf_y, neg_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg <= flags.par;
            hit_reg <= flags.hit && !flags.par;
            sat_reg <= (fx[OB] || fy[OB]) && !flags.par;
            x_reg   <= flags.par ? '0 : fx[OB-1:0];
            y_reg   <= flags.par ? '0 : fy[OB-1:0];
        end
    end

    assign segments_hit    = hit_reg;
    assign lines_parallel  = par_reg;
    assign point_saturated = sat_reg;
    assign cross_x         = x_reg;
    assign cross_y         = y_reg;

endmodule

// ----- rtl/core/sgi_checker.sv -----
// Port-level checker for the segment intersection unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sgi_checker
#(
    parameter int OUT_BITS = 34
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*OUT_BITS+7)/8)*8-1:0]      m_tdata,
    input logic [2:0]                           m_tuser
);

    localparam logic [OUT_BITS-1:0] MAXV = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] MINV = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic [OUT_BITS-1:0] cx, cy;
    logic at_edge;

    assign cx = m_tdata[OUT_BITS-1:0];
    assign cy = m_tdata[2*OUT_BITS-1:OUT_BITS];
    assign at_edge = (cx == MAXV) || (cx == MINV) || (cy == MAXV) || (cy == MINV);

    // A waiting result holds still.
    `SGI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Parallel lines give no point, no hit and no saturation.
    `SGI_ASSERT(a_parallel, m_tvalid && m_tuser[1], m_tuser[0] == 1'b0 && m_tuser[2] == 1'b0 && m_tdata == '0)

    // A clamped point has a coordinate at the end of the range.
    `SGI_ASSERT(a_sat_edge, m_tvalid && m_tuser[2], at_edge)

endmodule

bind segment_intersection_unit sgi_checker #(
    .OUT_BITS (COORD_BITS + FRAC_BITS + 2)
) u_sgi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
